/* hw/rtl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, register indexes and types of the look-at view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // vector fed to a normalizer: signed width and magnitude width
    localparam int CW  = DATA_W + FRAC_BITS + 2;
    localparam int MW  = CW - 1;
    // left-justify steps over the magnitude word
    localparam int NS  = $clog2(MW);
    // scaled magnitude, sum of squares, root
    localparam int M_W    = 30;
    localparam int SQ_W   = 2 * M_W + 2;
    localparam int SQX_W  = SQ_W + 1;
    localparam int LEN_W  = M_W + 1;
    // divider numerator and quotient
    localparam int NUM_W  = LEN_W + 1 + FRAC_BITS;
    localparam int Q_W    = FRAC_BITS + 1;
    // unit vector component and cross product component
    localparam int NV_W   = FRAC_BITS + 2;
    localparam int VV_W   = FRAC_BITS + 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_UP_X = 2'd0;
    localparam t_cfg_idx CFG_UP_Y = 2'd1;
    localparam t_cfg_idx CFG_UP_Z = 2'd2;

    localparam logic signed [DATA_W-1:0] UP_X_RST = '0;
    localparam logic signed [DATA_W-1:0] UP_Y_RST = DATA_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [DATA_W-1:0] UP_Z_RST = '0;

    // matrix rows
    typedef logic [1:0] t_row;
    localparam t_row ROW_U = 2'd0;
    localparam t_row ROW_V = 2'd1;
    localparam t_row ROW_N = 2'd2;

    typedef logic signed [CW-1:0]   t_cval;
    typedef logic signed [NV_W-1:0] t_nval;

    // data that rides along a normalizer
    typedef struct packed {
        logic [2:0][DATA_W-1:0] pos;
        logic [2:0][NV_W-1:0]   nrm;
        logic                   deg;
    } t_side;

endpackage

`default_nettype wire

/* hw/rtl/lav_if.sv */
// ----------------------------------------------------------------------------
// lav_if
// Request channels of the look-at view matrix block: camera in, rows out,
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lav_in_if;
    import lav_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] aim_x;
    logic signed [DATA_W-1:0] aim_y;
    logic signed [DATA_W-1:0] aim_z;
    modport source (output valid, pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, output ready);
endinterface

interface lav_out_if;
    import lav_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               row_index;
    logic signed [DATA_W-1:0] entry_x;
    logic signed [DATA_W-1:0] entry_y;
    logic signed [DATA_W-1:0] entry_z;
    logic signed [DATA_W-1:0] translation;
    logic                     degenerate;
    logic                     last_row;
    modport source (output valid, row_index, entry_x, entry_y, entry_z, translation,
                    degenerate, last_row, input ready);
    modport sink   (input valid, row_index, entry_x, entry_y, entry_z, translation,
                    degenerate, last_row, output ready);
endinterface

interface lav_cfg_if;
    import lav_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale to a 30-bit top, bit-serial square
// root, then three bit-serial dividers with round half up.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  lav_pkg::t_cval  i_c [3],
    input  lav_pkg::t_side  i_side,
    output logic            o_valid,
    output lav_pkg::t_nval  o_nrm [3],
    output lav_pkg::t_side  o_side
);
    import lav_pkg::*;

    typedef struct packed {
        logic [2:0] neg;
        t_side      side;
    } t_tag;

    // left-justify pipeline, index 0 holds the magnitudes
    logic           r_sh_vld [NS+1];
    logic [MW-1:0]  r_sh_mag [NS+1][3];
    logic [MW-1:0]  r_sh_or  [NS+1];
    t_tag           r_sh_tag [NS+1];

    logic [CW-1:0]  abs_c [3];
    logic [2:0]     neg_c;

    // magnitudes and sign of each component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_c[i] = i_c[i][CW-1];
            abs_c[i] = neg_c[i] ? (~i_c[i] + CW'(1)) : i_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sh_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sh_mag[0][i] <= abs_c[i][MW-1:0];
            end
            r_sh_or[0]       <= abs_c[0][MW-1:0] | abs_c[1][MW-1:0] | abs_c[2][MW-1:0];
            r_sh_tag[0].neg  <= neg_c;
            r_sh_tag[0].side <= i_side;
        end
    end

    // shift all three left until the common top bit is at the top
    for (genvar s = 0; s < NS; s++) begin : g_shift
        localparam int K = 1 << (NS - 1 - s);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sh_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_sh_vld[s+1] <= r_sh_vld[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh_tag[s+1] <= r_sh_tag[s];
                if (r_sh_or[s][MW-1 -: K] == '0) begin
                    r_sh_or[s+1] <= r_sh_or[s] << K;
                    for (int i = 0; i < 3; i++) begin
                        r_sh_mag[s+1][i] <= r_sh_mag[s][i] << K;
                    end
                end else begin
                    r_sh_or[s+1] <= r_sh_or[s];
                    for (int i = 0; i < 3; i++) begin
                        r_sh_mag[s+1][i] <= r_sh_mag[s][i];
                    end
                end
            end
        end
    end

    // squares of the scaled magnitudes
    logic                r_sq_vld;
    logic [2*M_W-1:0]    r_sq_p [3];
    logic [M_W-1:0]      r_sq_m [3];
    t_tag                r_sq_tag;
    logic [M_W-1:0]      sh_m [3];
    t_tag                sq_tag;

    // top bits of the scaled magnitudes, zero vector flagged
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh_m[i] = r_sh_mag[NS][i][MW-1 -: M_W];
        end
        sq_tag          = r_sh_tag[NS];
        sq_tag.side.deg = r_sh_tag[NS].side.deg | (r_sh_or[NS] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (i_en) begin
            r_sq_vld <= r_sh_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq_m[i] <= sh_m[i];
                r_sq_p[i] <= (2*M_W)'(sh_m[i]) * (2*M_W)'(sh_m[i]);
            end
            r_sq_tag <= sq_tag;
        end
    end

    // square root, one result bit per stage; index 0 holds the sum
    logic              r_rt_vld  [LEN_W+1];
    logic [SQ_W-1:0]   r_rt_rem  [LEN_W+1];
    logic [LEN_W-1:0]  r_rt_root [LEN_W+1];
    logic [M_W-1:0]    r_rt_m    [LEN_W+1][3];
    t_tag              r_rt_tag  [LEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_rt_vld[0] <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rt_rem[0]  <= SQ_W'(r_sq_p[0]) + SQ_W'(r_sq_p[1]) + SQ_W'(r_sq_p[2]);
            r_rt_root[0] <= '0;
            r_rt_m[0]    <= r_sq_m;
            r_rt_tag[0]  <= r_sq_tag;
        end
    end

    for (genvar j = 0; j < LEN_W; j++) begin : g_sqrt
        localparam int K = LEN_W - 1 - j;
        logic [SQX_W-1:0] trial;
        assign trial = (SQX_W'(r_rt_root[j]) << (K + 1)) + (SQX_W'(1) << (2 * K));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_rt_vld[j+1] <= r_rt_vld[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rt_m[j+1]   <= r_rt_m[j];
                r_rt_tag[j+1] <= r_rt_tag[j];
                if ({1'b0, r_rt_rem[j]} >= trial) begin
                    r_rt_rem[j+1]  <= r_rt_rem[j] - trial[SQ_W-1:0];
                    r_rt_root[j+1] <= r_rt_root[j] | (LEN_W'(1) << K);
                end else begin
                    r_rt_rem[j+1]  <= r_rt_rem[j];
                    r_rt_root[j+1] <= r_rt_root[j];
                end
            end
        end
    end

    // dividers, one quotient bit per stage; index 0 holds the rounded numerator
    logic              r_dv_vld [Q_W+1];
    logic [NUM_W-1:0]  r_dv_rem [Q_W+1][3];
    logic [Q_W-1:0]    r_dv_q   [Q_W+1][3];
    logic [LEN_W-1:0]  r_dv_len [Q_W+1];
    t_tag              r_dv_tag [Q_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_vld[0] <= r_rt_vld[LEN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= (NUM_W'(r_rt_m[LEN_W][i]) << FRAC_BITS)
                                + NUM_W'(r_rt_root[LEN_W] >> 1);
                r_dv_q[0][i]   <= '0;
            end
            r_dv_len[0] <= r_rt_root[LEN_W];
            r_dv_tag[0] <= r_rt_tag[LEN_W];
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int B = Q_W - 1 - j;
        logic [NUM_W-1:0] dsh;
        assign dsh = NUM_W'(r_dv_len[j]) << B;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_len[j+1] <= r_dv_len[j];
                r_dv_tag[j+1] <= r_dv_tag[j];
                for (int i = 0; i < 3; i++) begin
                    if (r_dv_rem[j][i] >= dsh) begin
                        r_dv_rem[j+1][i] <= r_dv_rem[j][i] - dsh;
                        r_dv_q[j+1][i]   <= r_dv_q[j][i] | (Q_W'(1) << B);
                    end else begin
                        r_dv_rem[j+1][i] <= r_dv_rem[j][i];
                        r_dv_q[j+1][i]   <= r_dv_q[j][i];
                    end
                end
            end
        end
    end

    // restore the signs
    logic  r_o_vld;
    t_nval r_o_nrm [3];
    t_tag  r_o_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_dv_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_o_nrm[i] <= r_dv_tag[Q_W].neg[i] ? -NV_W'(r_dv_q[Q_W][i])
                                                   :  NV_W'(r_dv_q[Q_W][i]);
            end
            r_o_tag <= r_dv_tag[Q_W];
        end
    end

    assign o_valid = r_o_vld;
    assign o_nrm   = r_o_nrm;
    assign o_side  = r_o_tag.side;

endmodule

`default_nettype wire

/* hw/rtl/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view matrix in signed fixed point: rows u, v, n with translations.
// ----------------------------------------------------------------------------
// Each accepted camera request (position and target) yields three row requests,
// u then v then n, each with its axis and the saturated translation -dot(axis,
// position). The up vector comes from three configuration registers, reset to
// (0, 1.0, 0), and may be written only while no request is in flight. The
// datapath is a stall-able pipeline that takes a request whenever it is not
// stalled; with 16 fraction bits most of its stages lie in the two normalizers
// (bit-serial square root and dividers). All three rows leave through one
// output register; a finished matrix waits until the previous one's row n is
// taken, stalling the pipeline meanwhile. A zero-length direction or an up vector
// parallel to it gives three zero rows with degenerate set.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lav_in_if.sink    i_in,
    lav_out_if.source o_out,
    lav_cfg_if.sink   i_cfg
);
    import lav_pkg::*;

    localparam int PV_W = 2 * NV_W;
    localparam int DV_W = PV_W + 1;
    localparam int PW   = VV_W + DATA_W;
    localparam int DW   = PW + 2;
    localparam int QT_W = DW - FRAC_BITS;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] t;
    } t_row_data;

    localparam logic [QT_W-1:0] Q_MAX_POS = QT_W'(64'h7FFF_FFFF);
    localparam logic [QT_W-1:0] Q_MAX_NEG = QT_W'(64'h8000_0000);
    localparam logic signed [DATA_W-1:0] SAT_POS = DATA_W'(64'h7FFF_FFFF);
    localparam logic signed [DATA_W-1:0] SAT_NEG = DATA_W'(64'h8000_0000);

    logic en;

    // configuration registers
    logic signed [DATA_W-1:0] r_up [3];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up[0] <= UP_X_RST;
            r_up[1] <= UP_Y_RST;
            r_up[2] <= UP_Z_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_UP_X: r_up[0] <= i_cfg.data;
                CFG_UP_Y: r_up[1] <= i_cfg.data;
                CFG_UP_Z: r_up[2] <= i_cfg.data;
                default:  ;
            endcase
        end
    end

    // input stage: direction vector
    logic signed [DATA_W-1:0] in_pos [3];
    logic signed [DATA_W-1:0] in_aim [3];
    logic        r_a_vld;
    t_cval       r_a_d [3];
    t_side       r_a_side;

    assign in_pos[0] = i_in.pos_x;
    assign in_pos[1] = i_in.pos_y;
    assign in_pos[2] = i_in.pos_z;
    assign in_aim[0] = i_in.aim_x;
    assign in_aim[1] = i_in.aim_y;
    assign in_aim[2] = i_in.aim_z;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_d[i]        <= t_cval'(in_aim[i]) - t_cval'(in_pos[i]);
                r_a_side.pos[i] <= in_pos[i];
            end
            r_a_side.nrm <= '0;
            r_a_side.deg <= 1'b0;
        end
    end

    // n = normalize(aim - pos)
    logic  n1_vld;
    t_nval n1_nrm [3];
    t_side n1_side;

    lav_norm u_norm_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_vld),
        .i_c     (r_a_d),
        .i_side  (r_a_side),
        .o_valid (n1_vld),
        .o_nrm   (n1_nrm),
        .o_side  (n1_side)
    );

    // up x n: products then differences
    logic  r_x1_vld;
    t_cval r_x1_p [6];
    t_side r_x1_side;
    logic  r_x2_vld;
    t_cval r_x2_cu [3];
    t_side r_x2_side;
    t_side x1_side;

    // n rides along for the v stage
    always_comb begin
        x1_side = n1_side;
        for (int i = 0; i < 3; i++) begin
            x1_side.nrm[i] = n1_nrm[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_vld <= 1'b0;
            r_x2_vld <= 1'b0;
        end else if (en) begin
            r_x1_vld <= n1_vld;
            r_x2_vld <= r_x1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1_p[0] <= t_cval'(r_up[1]) * t_cval'(n1_nrm[2]);
            r_x1_p[1] <= t_cval'(r_up[2]) * t_cval'(n1_nrm[1]);
            r_x1_p[2] <= t_cval'(r_up[2]) * t_cval'(n1_nrm[0]);
            r_x1_p[3] <= t_cval'(r_up[0]) * t_cval'(n1_nrm[2]);
            r_x1_p[4] <= t_cval'(r_up[0]) * t_cval'(n1_nrm[1]);
            r_x1_p[5] <= t_cval'(r_up[1]) * t_cval'(n1_nrm[0]);
            r_x1_side <= x1_side;
            for (int i = 0; i < 3; i++) begin
                r_x2_cu[i] <= r_x1_p[2*i] - r_x1_p[2*i+1];
            end
            r_x2_side <= r_x1_side;
        end
    end

    // u = normalize(up x n)
    logic  n2_vld;
    t_nval n2_u [3];
    t_side n2_side;

    lav_norm u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_x2_vld),
        .i_c     (r_x2_cu),
        .i_side  (r_x2_side),
        .o_valid (n2_vld),
        .o_nrm   (n2_u),
        .o_side  (n2_side)
    );

    // v = n x u with rounding
    t_nval nn [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nn[i] = $signed(n2_side.nrm[i]);
        end
    end

    logic                   r_v1_vld, r_v2_vld, r_v3_vld, r_v4_vld;
    logic signed [PV_W-1:0] r_v1_p [6];
    logic signed [DV_W-1:0] r_v2_d [3];
    logic [DV_W-1:0]        r_v3_mag [3];
    logic [2:0]             r_v3_neg;
    t_nval                  r_v1_u [3], r_v2_u [3], r_v3_u [3];
    t_side                  r_v1_side, r_v2_side, r_v3_side;
    logic signed [VV_W-1:0] r_v4_ax [3][3];
    logic [2:0][DATA_W-1:0] r_v4_pos;
    logic                   r_v4_deg;
    logic [DV_W-1:0]        v_sum [3];
    logic [DV_W-FRAC_BITS-1:0] v_q [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_sum[i] = r_v3_mag[i] + (DV_W'(1) << (FRAC_BITS - 1));
            v_q[i]   = v_sum[i][DV_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_vld <= 1'b0;
            r_v2_vld <= 1'b0;
            r_v3_vld <= 1'b0;
            r_v4_vld <= 1'b0;
        end else if (en) begin
            r_v1_vld <= n2_vld;
            r_v2_vld <= r_v1_vld;
            r_v3_vld <= r_v2_vld;
            r_v4_vld <= r_v3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1_p[0] <= PV_W'(nn[1]) * PV_W'(n2_u[2]);
            r_v1_p[1] <= PV_W'(nn[2]) * PV_W'(n2_u[1]);
            r_v1_p[2] <= PV_W'(nn[2]) * PV_W'(n2_u[0]);
            r_v1_p[3] <= PV_W'(nn[0]) * PV_W'(n2_u[2]);
            r_v1_p[4] <= PV_W'(nn[0]) * PV_W'(n2_u[1]);
            r_v1_p[5] <= PV_W'(nn[1]) * PV_W'(n2_u[0]);
            r_v1_u    <= n2_u;
            r_v1_side <= n2_side;
            for (int i = 0; i < 3; i++) begin
                r_v2_d[i]   <= DV_W'(r_v1_p[2*i]) - DV_W'(r_v1_p[2*i+1]);
                r_v3_neg[i] <= r_v2_d[i][DV_W-1];
                r_v3_mag[i] <= r_v2_d[i][DV_W-1] ? DV_W'(-r_v2_d[i]) : DV_W'(r_v2_d[i]);
                r_v4_ax[0][i] <= VV_W'(r_v3_u[i]);
                r_v4_ax[1][i] <= r_v3_neg[i] ? -VV_W'(v_q[i]) : VV_W'(v_q[i]);
                r_v4_ax[2][i] <= VV_W'($signed(r_v3_side.nrm[i]));
            end
            r_v2_u    <= r_v1_u;
            r_v2_side <= r_v1_side;
            r_v3_u    <= r_v2_u;
            r_v3_side <= r_v2_side;
            r_v4_pos  <= r_v3_side.pos;
            r_v4_deg  <= r_v3_side.deg;
        end
    end

    // translations: dot products, rounding, saturation
    logic                   r_t1_vld, r_t2_vld, r_t3_vld, r_t4_vld, r_t5_vld, r_t6_vld;
    logic signed [PW-1:0]   r_t1_p [3][3];
    logic signed [PW:0]     r_t2_s [3];
    logic signed [PW-1:0]   r_t2_p2 [3];
    logic signed [DW-1:0]   r_t3_dot [3];
    logic [DW-1:0]          r_t4_mag [3];
    logic [2:0]             r_t4_neg, r_t5_neg;
    logic [QT_W-1:0]        r_t5_q [3];
    logic signed [VV_W-1:0] r_t1_ax [3][3], r_t2_ax [3][3], r_t3_ax [3][3];
    logic signed [VV_W-1:0] r_t4_ax [3][3], r_t5_ax [3][3];
    logic                   r_t1_deg, r_t2_deg, r_t3_deg, r_t4_deg, r_t5_deg, r_t6_deg;
    t_row_data              r_t6_row [3];
    logic [DW-1:0]          t_sum [3];
    logic signed [DATA_W-1:0] t_val [3];

    // round half up on the magnitude, then sign and saturate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            t_sum[r] = r_t4_mag[r] + (DW'(1) << (FRAC_BITS - 1));
            if (r_t5_neg[r]) begin
                t_val[r] = (r_t5_q[r] > Q_MAX_NEG) ? SAT_NEG : -DATA_W'(r_t5_q[r]);
            end else begin
                t_val[r] = (r_t5_q[r] > Q_MAX_POS) ? SAT_POS : DATA_W'(r_t5_q[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
            r_t3_vld <= 1'b0;
            r_t4_vld <= 1'b0;
            r_t5_vld <= 1'b0;
            r_t6_vld <= 1'b0;
        end else if (en) begin
            r_t1_vld <= r_v4_vld;
            r_t2_vld <= r_t1_vld;
            r_t3_vld <= r_t2_vld;
            r_t4_vld <= r_t3_vld;
            r_t5_vld <= r_t4_vld;
            r_t6_vld <= r_t5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    r_t1_p[r][i] <= PW'(r_v4_ax[r][i]) * PW'($signed(r_v4_pos[i]));
                end
                r_t2_s[r]   <= (PW+1)'(r_t1_p[r][0]) + (PW+1)'(r_t1_p[r][1]);
                r_t2_p2[r]  <= r_t1_p[r][2];
                r_t3_dot[r] <= DW'(r_t2_s[r]) + DW'(r_t2_p2[r]);
                r_t4_neg[r] <= !r_t3_dot[r][DW-1] && (r_t3_dot[r] != '0);
                r_t4_mag[r] <= r_t3_dot[r][DW-1] ? DW'(-r_t3_dot[r]) : DW'(r_t3_dot[r]);
                r_t5_q[r]   <= t_sum[r][DW-1:FRAC_BITS];
                if (r_t5_deg) begin
                    r_t6_row[r] <= '0;
                end else begin
                    r_t6_row[r].x <= DATA_W'(r_t5_ax[r][0]);
                    r_t6_row[r].y <= DATA_W'(r_t5_ax[r][1]);
                    r_t6_row[r].z <= DATA_W'(r_t5_ax[r][2]);
                    r_t6_row[r].t <= t_val[r];
                end
            end
            r_t5_neg <= r_t4_neg;
            r_t1_ax  <= r_v4_ax;
            r_t2_ax  <= r_t1_ax;
            r_t3_ax  <= r_t2_ax;
            r_t4_ax  <= r_t3_ax;
            r_t5_ax  <= r_t4_ax;
            r_t1_deg <= r_v4_deg;
            r_t2_deg <= r_t1_deg;
            r_t3_deg <= r_t2_deg;
            r_t4_deg <= r_t3_deg;
            r_t5_deg <= r_t4_deg;
            r_t6_deg <= r_t5_deg;
        end
    end

    // output register: sends the three rows of one matrix
    t_row_data r_ob_row [3];
    logic      r_ob_deg;
    logic      r_ob_full;
    t_row      r_ob_idx;
    t_row      n_ob_idx;
    logic      load;
    logic      take;

    assign take = r_ob_full && o_out.ready;
    assign en   = !r_t6_vld || !r_ob_full || (o_out.ready && (r_ob_idx == ROW_N));
    assign load = en && r_t6_vld;

    always_comb begin
        case (r_ob_idx)
            ROW_U:   n_ob_idx = ROW_V;
            ROW_V:   n_ob_idx = ROW_N;
            default: n_ob_idx = ROW_U;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_full <= 1'b0;
            r_ob_idx  <= ROW_U;
        end else if (load) begin
            r_ob_full <= 1'b1;
            r_ob_idx  <= ROW_U;
        end else if (take) begin
            r_ob_full <= (r_ob_idx != ROW_N);
            r_ob_idx  <= n_ob_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ob_row <= r_t6_row;
            r_ob_deg <= r_t6_deg;
        end
    end

    // row select
    t_row_data ob_sel;
    always_comb begin
        case (r_ob_idx)
            ROW_U:   ob_sel = r_ob_row[0];
            ROW_V:   ob_sel = r_ob_row[1];
            default: ob_sel = r_ob_row[2];
        endcase
    end

    assign o_out.valid       = r_ob_full;
    assign o_out.row_index   = r_ob_idx;
    assign o_out.entry_x     = ob_sel.x;
    assign o_out.entry_y     = ob_sel.y;
    assign o_out.entry_z     = ob_sel.z;
    assign o_out.translation = ob_sel.t;
    assign o_out.degenerate  = r_ob_deg;
    assign o_out.last_row    = (r_ob_idx == ROW_N);

endmodule

`default_nettype wire

/* hw/rtl/lav_chk.sv */
// ----------------------------------------------------------------------------
// lav_chk
// Port-level checks on the row output of the look-at view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [1:0]                   i_row_index,
    input logic [lav_pkg::DATA_W-1:0]   i_entry_x,
    input logic [lav_pkg::DATA_W-1:0]   i_entry_y,
    input logic [lav_pkg::DATA_W-1:0]   i_entry_z,
    input logic [lav_pkg::DATA_W-1:0]   i_translation,
    input logic                         i_degenerate,
    input logic                         i_last_row
);
    import lav_pkg::*;

    // a stalled row request stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_row_index))
        else $error("row request dropped while stalled");

    // rows of one matrix follow each other with the same degenerate flag
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_row |=>
            i_out_valid && (i_row_index == $past(i_row_index) + 2'd1)
            && (i_degenerate == $past(i_degenerate)))
        else $error("matrix rows out of sequence");

    // last row marks row n
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_row == (i_row_index == ROW_N)))
        else $error("last_row does not match row index");

    // degenerate rows are all zero
    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |->
            (i_entry_x == '0) && (i_entry_y == '0) && (i_entry_z == '0)
            && (i_translation == '0))
        else $error("degenerate row not zero");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_row_index   (o_out.row_index),
    .i_entry_x     (o_out.entry_x),
    .i_entry_y     (o_out.entry_y),
    .i_entry_z     (o_out.entry_z),
    .i_translation (o_out.translation),
    .i_degenerate  (o_out.degenerate),
    .i_last_row    (o_out.last_row)
);

`default_nettype wire
